// ===== rtl/ddcs_pkg.sv =====
// Package: shared types, codes and constants of the differential drive command sequencer.
`timescale 1ns / 1ps
package ddcs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SPEED_W    = 13;
  localparam int ANGLE_W    = 13;
  localparam int CODE_W     = 4;
  localparam int TIME_W     = 11;
  localparam int WIDE_W     = 20;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_BIAS   = 3'd5;

  localparam logic [11:0]        RST_BASE_SPEED  = 12'd480;
  localparam logic [11:0]        RST_STEER_GAIN  = 12'd256;
  localparam logic [11:0]        RST_ANGLE_LIMIT = 12'd720;
  localparam logic signed [12:0] RST_WHEEL_MIN   = -13'sd1600;
  localparam logic [11:0]        RST_WHEEL_MAX   = 12'd1600;
  localparam logic [9:0]         RST_SIDE_BIAS   = 10'd80;

  localparam logic [TIME_W-1:0] TIME_MAX      = 11'd2047;
  localparam logic [TIME_W-1:0] PARK_BACK_MS  = 11'd2000;
  localparam logic [TIME_W-1:0] PARK_TURN_MS  = 11'd1000;
  localparam logic [TIME_W-1:0] PARK_FWD_MS   = 11'd500;
  localparam logic [TIME_W-1:0] EVADE_MS      = 11'd500;

  localparam logic signed [SPEED_W-1:0] SPD_ZERO   = 13'sd0;
  localparam logic signed [SPEED_W-1:0] SPD_REV_HI = -13'sd320;
  localparam logic signed [SPEED_W-1:0] SPD_REV_LO = -13'sd160;
  localparam logic signed [SPEED_W-1:0] SPD_FWD_MD = 13'sd240;
  localparam logic signed [SPEED_W-1:0] SPD_FWD_HI = 13'sd320;
  localparam logic signed [SPEED_W-1:0] SPD_FWD_LO = 13'sd80;

  localparam logic [7:0] SCALE_NOLANE_Q8 = 8'd205;

  typedef enum logic {
    ACT_CLASS = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  typedef enum logic [CODE_W-1:0] {
    CMD_START      = 4'd0,
    CMD_STOP       = 4'd1,
    CMD_NORMAL     = 4'd2,
    CMD_KEEP       = 4'd3,
    CMD_NO_LANE    = 4'd4,
    CMD_PARK       = 4'd5,
    CMD_HUMAN      = 4'd6,
    CMD_OBSTACLE   = 4'd7,
    CMD_CROSSWALK  = 4'd8,
    CMD_BIAS_LEFT  = 4'd9,
    CMD_BIAS_RIGHT = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    RT_IDLE   = 3'd0,
    RT_PARK1  = 3'd1,
    RT_PARK2  = 3'd2,
    RT_PARK3  = 3'd3,
    RT_EVADE1 = 3'd4,
    RT_EVADE2 = 3'd5
  } routine_t;

  typedef enum logic [1:0] {
    SCL_FULL   = 2'd0,
    SCL_NOLANE = 2'd1,
    SCL_HALF   = 2'd2
  } scale_t;

  typedef enum logic [1:0] {
    BIAS_NONE  = 2'd0,
    BIAS_LEFT  = 2'd1,
    BIAS_RIGHT = 2'd2
  } bias_t;

  typedef struct packed {
    logic [11:0]        base_speed;
    logic [11:0]        steer_gain;
    logic [11:0]        angle_limit;
    logic signed [12:0] wheel_min;
    logic [11:0]        wheel_max;
    logic [9:0]         side_bias;
  } cfg_t;

  typedef struct packed {
    logic                       emit;
    logic                       steer;
    logic                       zero_angle;
    scale_t                     scale;
    bias_t                      bias;
    logic signed [SPEED_W-1:0]  fix_left;
    logic signed [SPEED_W-1:0]  fix_right;
  } drive_req_t;

endpackage

// ===== rtl/ddcs_if.sv =====
// Interfaces: command input channel and wheel goal result channel.
`timescale 1ns / 1ps
interface ddcs_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [3:0]         class_code;
  logic signed [12:0] angle;

  modport source (output valid, action, class_code, angle, input ready);
  modport sink   (input valid, action, class_code, angle, output ready);
endinterface

interface ddcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] left_speed;
  logic signed [12:0] right_speed;

  modport source (output valid, left_speed, right_speed, input ready);
  modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

// ===== rtl/ddcs_cfg.sv =====
// Configuration register file with write-only port.
`timescale 1ns / 1ps
module ddcs_cfg (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [ddcs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ddcs_pkg::CFG_DATA_W-1:0]        cfg_data,
  output ddcs_pkg::cfg_t                         cfg
);
  import ddcs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_SPEED:  cfg_nxt.base_speed  = cfg_data[11:0];
        REG_STEER_GAIN:  cfg_nxt.steer_gain  = cfg_data[11:0];
        REG_ANGLE_LIMIT: cfg_nxt.angle_limit = cfg_data[11:0];
        REG_WHEEL_MIN:   cfg_nxt.wheel_min   = $signed(cfg_data[12:0]);
        REG_WHEEL_MAX:   cfg_nxt.wheel_max   = cfg_data[11:0];
        REG_SIDE_BIAS:   cfg_nxt.side_bias   = cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed  <= RST_BASE_SPEED;
      cfg_r.steer_gain  <= RST_STEER_GAIN;
      cfg_r.angle_limit <= RST_ANGLE_LIMIT;
      cfg_r.wheel_min   <= RST_WHEEL_MIN;
      cfg_r.wheel_max   <= RST_WHEEL_MAX;
      cfg_r.side_bias   <= RST_SIDE_BIAS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/ddcs_ctrl.sv =====
// Command decoder with enable flag, timed routine state and step timer.
`timescale 1ns / 1ps
module ddcs_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  logic                             action,
  input  logic [ddcs_pkg::CODE_W-1:0]      class_code,
  output ddcs_pkg::drive_req_t             req
);
  import ddcs_pkg::*;

  logic              drive_on_r, drive_on_nxt;
  routine_t          step_r, step_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] time_inc;
  logic              step_idle;

  assign time_inc  = (time_r < TIME_MAX) ? time_r + 11'd1 : time_r;
  assign step_idle = (step_r == RT_IDLE);

  always_comb begin
    drive_on_nxt = drive_on_r;
    step_nxt     = step_r;
    time_nxt     = time_r;
    req          = '0;
    req.scale    = SCL_FULL;
    req.bias     = BIAS_NONE;
    if (action == ACT_TICK) begin
      req.emit = 1'b1;
      time_nxt = time_inc;
      unique case (step_r)
        RT_PARK1: begin
          req.fix_left  = SPD_REV_HI;
          req.fix_right = SPD_REV_LO;
          if (time_inc >= PARK_BACK_MS) begin
            step_nxt = RT_PARK2;
            time_nxt = '0;
          end
        end
        RT_PARK2: begin
          req.fix_left  = SPD_REV_HI;
          req.fix_right = SPD_REV_HI;
          if (time_inc >= PARK_TURN_MS) begin
            step_nxt = RT_PARK3;
            time_nxt = '0;
          end
        end
        RT_PARK3: begin
          if (time_inc >= PARK_FWD_MS) begin
            req.fix_left  = SPD_ZERO;
            req.fix_right = SPD_ZERO;
            step_nxt      = RT_IDLE;
            time_nxt      = '0;
          end else begin
            req.fix_left  = SPD_FWD_MD;
            req.fix_right = SPD_FWD_MD;
          end
        end
        RT_EVADE1: begin
          req.fix_left  = SPD_FWD_HI;
          req.fix_right = SPD_FWD_LO;
          if (time_inc >= EVADE_MS) begin
            step_nxt = RT_EVADE2;
            time_nxt = '0;
          end
        end
        RT_EVADE2: begin
          req.fix_left  = SPD_FWD_LO;
          req.fix_right = SPD_FWD_HI;
          if (time_inc >= EVADE_MS) begin
            step_nxt = RT_IDLE;
            time_nxt = '0;
          end
        end
        default: begin
          req.emit = 1'b0;
          time_nxt = time_r;
        end
      endcase
    end else begin
      priority if (class_code == CMD_START) begin
        drive_on_nxt = 1'b1;
        step_nxt     = RT_IDLE;
        time_nxt     = '0;
        req.emit     = 1'b1;
        req.steer    = 1'b1;
      end else if (class_code == CMD_STOP) begin
        drive_on_nxt = 1'b0;
        step_nxt     = RT_IDLE;
        time_nxt     = '0;
        req.emit     = 1'b1;
      end else if (drive_on_r) begin
        unique case (cmd_t'(class_code))
          CMD_NORMAL: begin
            req.emit  = step_idle;
            req.steer = 1'b1;
          end
          CMD_NO_LANE: begin
            req.emit       = step_idle;
            req.steer      = 1'b1;
            req.zero_angle = 1'b1;
            req.scale      = SCL_NOLANE;
          end
          CMD_PARK: begin
            step_nxt = RT_PARK1;
            time_nxt = '0;
          end
          CMD_HUMAN: begin
            step_nxt = RT_IDLE;
            time_nxt = '0;
            req.emit = 1'b1;
          end
          CMD_OBSTACLE: begin
            step_nxt = RT_EVADE1;
            time_nxt = '0;
          end
          CMD_CROSSWALK: begin
            req.emit  = step_idle;
            req.steer = 1'b1;
            req.scale = SCL_HALF;
          end
          CMD_BIAS_LEFT: begin
            req.emit  = step_idle;
            req.steer = 1'b1;
            req.bias  = BIAS_LEFT;
          end
          CMD_BIAS_RIGHT: begin
            req.emit  = step_idle;
            req.steer = 1'b1;
            req.bias  = BIAS_RIGHT;
          end
          default: ;
        endcase
      end else begin
        req.emit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_on_r <= 1'b0;
      step_r     <= RT_IDLE;
      time_r     <= '0;
    end else if (fire) begin
      drive_on_r <= drive_on_nxt;
      step_r     <= step_nxt;
      time_r     <= time_nxt;
    end
  end

endmodule

// ===== rtl/ddcs_steer.sv =====
// Wheel goal datapath: angle clamp, gain multiply, base scaling, bias and speed clamp.
`timescale 1ns / 1ps
module ddcs_steer (
  input  ddcs_pkg::cfg_t                          cfg,
  input  ddcs_pkg::drive_req_t                    req,
  input  logic signed [ddcs_pkg::ANGLE_W-1:0]     angle,
  output logic signed [ddcs_pkg::SPEED_W-1:0]     left_speed,
  output logic signed [ddcs_pkg::SPEED_W-1:0]     right_speed
);
  import ddcs_pkg::*;

  logic signed [ANGLE_W-1:0] lim_pos, lim_neg, ang_c;
  logic signed [ANGLE_W-1:0] gain_s;
  logic signed [25:0]        prod, prod_rnd;
  logic signed [18:0]        diff;
  logic signed [18:0]        bias_s;
  logic [19:0]               nolane_prod;
  logic [12:0]               half_sum;
  logic [12:0]               base;
  logic signed [WIDE_W-1:0]  base_w, diff_w, left_raw, right_raw;
  logic signed [WIDE_W-1:0]  wmin_w, wmax_w;

  assign lim_pos = $signed({1'b0, cfg.angle_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (req.zero_angle)        ang_c = '0;
    else if (angle < lim_neg)  ang_c = lim_neg;
    else if (angle > lim_pos)  ang_c = lim_pos;
    else                       ang_c = angle;
  end

  assign gain_s   = $signed({1'b0, cfg.steer_gain});
  assign prod     = ang_c * gain_s;
  assign prod_rnd = prod + 26'sd128;

  always_comb begin
    unique case (req.bias)
      BIAS_LEFT:  bias_s = $signed({9'd0, cfg.side_bias});
      BIAS_RIGHT: bias_s = -$signed({9'd0, cfg.side_bias});
      default:    bias_s = '0;
    endcase
  end

  assign diff = $signed(prod_rnd[25:8]) + bias_s;

  assign nolane_prod = {8'd0, cfg.base_speed} * {12'd0, SCALE_NOLANE_Q8} + 20'd128;
  assign half_sum    = {1'b0, cfg.base_speed} + 13'd1;

  always_comb begin
    unique case (req.scale)
      SCL_NOLANE: base = {1'b0, nolane_prod[19:8]};
      SCL_HALF:   base = {1'b0, half_sum[12:1]};
      default:    base = {1'b0, cfg.base_speed};
    endcase
  end

  assign base_w = $signed({7'd0, base});
  assign diff_w = WIDE_W'(diff);

  always_comb begin
    if (req.steer) begin
      left_raw  = base_w + diff_w;
      right_raw = base_w - diff_w;
    end else begin
      left_raw  = WIDE_W'(req.fix_left);
      right_raw = WIDE_W'(req.fix_right);
    end
  end

  assign wmin_w = WIDE_W'(cfg.wheel_min);
  assign wmax_w = $signed({8'd0, cfg.wheel_max});

  always_comb begin
    if (left_raw < wmin_w)       left_speed = cfg.wheel_min;
    else if (left_raw > wmax_w)  left_speed = $signed({1'b0, cfg.wheel_max});
    else                         left_speed = left_raw[SPEED_W-1:0];
    if (right_raw < wmin_w)      right_speed = cfg.wheel_min;
    else if (right_raw > wmax_w) right_speed = $signed({1'b0, cfg.wheel_max});
    else                         right_speed = right_raw[SPEED_W-1:0];
  end

endmodule

// ===== rtl/differential_drive_command_sequencer.sv =====
// Top level: input register, command control, wheel goal datapath and result register.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          action, class_code, angle
//  out_ch    out  valid/ready          left_speed, right_speed
//  cfg_*     in   cfg_we (no stall)    cfg_index, cfg_data
//
//  One transaction per cycle sustained while out_ch is ready, through input and result registers.
//  The rate is set by the single pass from input register through the gain multiplier
//  and speed clamp into the result register.
//  Reset clears both stage valids, the enable flag, the routine step and the step timer.
//  A stalled result holds the input register; in_ch.ready follows out_ch.ready combinationally.
//  Transactions that give no result leave without occupying the result register.
`timescale 1ns / 1ps
module differential_drive_command_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  ddcs_in_if.sink                             in_ch,
  ddcs_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [ddcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ddcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ddcs_pkg::*;

  cfg_t                      cfg;
  drive_req_t                req;
  logic                      s1_valid_r;
  logic                      s1_action_r;
  logic [CODE_W-1:0]         s1_code_r;
  logic signed [ANGLE_W-1:0] s1_angle_r;
  logic                      out_valid_r;
  logic signed [SPEED_W-1:0] out_left_r, out_right_r;
  logic signed [SPEED_W-1:0] left_nxt, right_nxt;
  logic                      advance, fire, in_fire;

  assign advance = !out_valid_r || out_ch.ready;
  assign fire    = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire = in_ch.valid && in_ch.ready;

  ddcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ddcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .action     (s1_action_r),
    .class_code (s1_code_r),
    .req        (req)
  );

  ddcs_steer u_steer (
    .cfg         (cfg),
    .req         (req),
    .angle       (s1_angle_r),
    .left_speed  (left_nxt),
    .right_speed (right_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_ch.action;
      s1_code_r   <= in_ch.class_code;
      s1_angle_r  <= in_ch.angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && req.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && req.emit) begin
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_speed  = out_left_r;
  assign out_ch.right_speed = out_right_r;

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench: random and directed commands against a cycle-free wheel goal predictor.
`timescale 1ns / 1ps
module testbench;
  import ddcs_pkg::*;

  typedef struct packed {
    action_t            action;
    logic [3:0]         code;
    logic signed [12:0] angle;
  } drive_cmd_t;

  typedef struct packed {
    logic signed [12:0] left_spd;
    logic signed [12:0] right_spd;
  } wheel_goal_t;

  localparam int SCALE_FULL = 256;
  localparam int SCALE_HALF = 128;
  localparam int ANGLE_MAX  = 4095;
  localparam int ANGLE_MIN  = -4096;
  localparam logic [3:0] CODE_SPARE_LO = 4'd11;
  localparam logic [3:0] CODE_SPARE_HI = 4'd15;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ddcs_in_if  in_ch();
  ddcs_out_if out_ch();

  differential_drive_command_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  drive_cmd_t  pend_q[$];
  wheel_goal_t goal_q[$];
  int          queued;
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        in_taken;

  cfg_t        drive_cfg;
  logic        drive_en;
  routine_t    step_now;
  logic [10:0] step_ms;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic signed [12:0] clamp_speed(int v);
    int lo, hi, r;
    lo = $signed(drive_cfg.wheel_min);
    hi = drive_cfg.wheel_max;
    r  = v;
    if (r < lo) r = lo;
    else if (r > hi) r = hi;
    return r[12:0];
  endfunction

  function automatic wheel_goal_t make_goal(int l, int r);
    wheel_goal_t g;
    g.left_spd  = clamp_speed(l);
    g.right_spd = clamp_speed(r);
    return g;
  endfunction

  function automatic bit steer_goal(int ang, int scale, int bias, output wheel_goal_t g);
    int lim, a, base, diff;
    if (!drive_en || step_now != RT_IDLE) return 1'b0;
    lim = drive_cfg.angle_limit;
    a   = ang;
    if (a < -lim) a = -lim;
    if (a > lim) a = lim;
    base = (int'(drive_cfg.base_speed) * scale + 128) >>> 8;
    diff = ((a * int'(drive_cfg.steer_gain) + 128) >>> 8) + bias;
    g = make_goal(base + diff, base - diff);
    return 1'b1;
  endfunction

  function automatic bit next_goal(input drive_cmd_t c, output wheel_goal_t g);
    int ang;
    ang = c.angle;
    if (c.action == ACT_TICK) begin
      if (step_now == RT_IDLE || step_now > RT_EVADE2) return 1'b0;
      if (step_ms < TIME_MAX) step_ms = step_ms + 11'd1;
      case (step_now)
        RT_PARK1: begin
          if (step_ms >= PARK_BACK_MS) begin
            step_now = RT_PARK2;
            step_ms  = '0;
          end
          g = make_goal(SPD_REV_HI, SPD_REV_LO);
        end
        RT_PARK2: begin
          if (step_ms >= PARK_TURN_MS) begin
            step_now = RT_PARK3;
            step_ms  = '0;
          end
          g = make_goal(SPD_REV_HI, SPD_REV_HI);
        end
        RT_PARK3: begin
          if (step_ms >= PARK_FWD_MS) begin
            step_now = RT_IDLE;
            step_ms  = '0;
            g = make_goal(SPD_ZERO, SPD_ZERO);
          end else begin
            g = make_goal(SPD_FWD_MD, SPD_FWD_MD);
          end
        end
        RT_EVADE1: begin
          if (step_ms >= EVADE_MS) begin
            step_now = RT_EVADE2;
            step_ms  = '0;
          end
          g = make_goal(SPD_FWD_HI, SPD_FWD_LO);
        end
        default: begin
          if (step_ms >= EVADE_MS) begin
            step_now = RT_IDLE;
            step_ms  = '0;
          end
          g = make_goal(SPD_FWD_LO, SPD_FWD_HI);
        end
      endcase
      return 1'b1;
    end
    if (c.code == CMD_START) begin
      drive_en = 1'b1;
      step_now = RT_IDLE;
      step_ms  = '0;
      return steer_goal(ang, SCALE_FULL, 0, g);
    end
    if (c.code == CMD_STOP) begin
      drive_en = 1'b0;
      step_now = RT_IDLE;
      step_ms  = '0;
      g = make_goal(SPD_ZERO, SPD_ZERO);
      return 1'b1;
    end
    if (!drive_en) return 1'b0;
    case (c.code)
      CMD_NORMAL:     return steer_goal(ang, SCALE_FULL, 0, g);
      CMD_NO_LANE:    return steer_goal(0, SCALE_NOLANE_Q8, 0, g);
      CMD_CROSSWALK:  return steer_goal(ang, SCALE_HALF, 0, g);
      CMD_BIAS_LEFT:  return steer_goal(ang, SCALE_FULL, drive_cfg.side_bias, g);
      CMD_BIAS_RIGHT: return steer_goal(ang, SCALE_FULL, -int'(drive_cfg.side_bias), g);
      CMD_PARK: begin
        step_now = RT_PARK1;
        step_ms  = '0;
      end
      CMD_OBSTACLE: begin
        step_now = RT_EVADE1;
        step_ms  = '0;
      end
      CMD_HUMAN: begin
        step_now = RT_IDLE;
        step_ms  = '0;
        g = make_goal(SPD_ZERO, SPD_ZERO);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  always @(negedge clk) begin : drive_cmds
    drive_cmd_t nxt;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pend_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.action     <= nxt.action;
        in_ch.class_code <= nxt.code;
        in_ch.angle      <= nxt.angle;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : watch_goals
    wheel_goal_t got, want;
    drive_cmd_t  cmd;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.left_spd  = out_ch.left_speed;
      got.right_spd = out_ch.right_speed;
      if (goal_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected wheel goal left %0d right %0d", got.left_spd, got.right_spd);
      end else begin
        want = goal_q.pop_front();
        if (got.left_spd !== want.left_spd || got.right_spd !== want.right_spd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("wheel goal mismatch: expected %0d/%0d, got %0d/%0d",
                     want.left_spd, want.right_spd, got.left_spd, got.right_spd);
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      cmd.action = action_t'(in_ch.action);
      cmd.code   = in_ch.class_code;
      cmd.angle  = in_ch.angle;
      if (next_goal(cmd, want)) goal_q.push_back(want);
    end
  end

  task automatic push_cmd(action_t act, logic [3:0] code, int ang);
    drive_cmd_t c;
    c.action = act;
    c.code   = code;
    c.angle  = ang[12:0];
    pend_q.push_back(c);
    queued++;
  endtask

  function automatic int pick_angle();
    int lim;
    lim = drive_cfg.angle_limit;
    case ($urandom_range(5))
      0: return $urandom_range(1) ? ANGLE_MAX : ANGLE_MIN;
      1: return ($urandom_range(1) ? 1 : -1) * (lim + $urandom_range(2) - 1);
      default: return $signed(13'($urandom()));
    endcase
  endfunction

  task automatic push_tick();
    push_cmd(ACT_TICK, 4'($urandom_range(15)), pick_angle());
  endtask

  function automatic logic [3:0] pick_steer();
    case ($urandom_range(5))
      0: return CMD_NORMAL;
      1: return CMD_NO_LANE;
      2: return CMD_CROSSWALK;
      3: return CMD_BIAS_LEFT;
      4: return CMD_BIAS_RIGHT;
      default: return CMD_KEEP;
    endcase
  endfunction

  function automatic logic [3:0] pick_exit();
    case ($urandom_range(4))
      0: return CMD_HUMAN;
      1: return CMD_START;
      2: return CMD_STOP;
      3: return CMD_PARK;
      default: return CMD_OBSTACLE;
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 13'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE_SPEED:  drive_cfg.base_speed  = val[11:0];
      REG_STEER_GAIN:  drive_cfg.steer_gain  = val[11:0];
      REG_ANGLE_LIMIT: drive_cfg.angle_limit = val[11:0];
      REG_WHEEL_MIN:   drive_cfg.wheel_min   = val[12:0];
      REG_WHEEL_MAX:   drive_cfg.wheel_max   = val[11:0];
      REG_SIDE_BIAS:   drive_cfg.side_bias   = val[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int base, int gain, int lim, int lo, int hi, int bias);
    write_reg(REG_BASE_SPEED, base);
    write_reg(REG_STEER_GAIN, gain);
    write_reg(REG_ANGLE_LIMIT, lim);
    write_reg(REG_WHEEL_MIN, lo);
    write_reg(REG_WHEEL_MAX, hi);
    write_reg(REG_SIDE_BIAS, bias);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  task automatic settle();
    while (pend_q.size() != 0 || in_ch.valid || goal_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_random_burst(int n);
    int stop_at;
    stop_at = queued + n;
    while (queued < stop_at) begin
      case ($urandom_range(9))
        0, 1: push_cmd(action_t'($urandom_range(1)), 4'($urandom_range(15)), pick_angle());
        2, 3, 4: begin
          if ($urandom_range(3) != 0) push_cmd(ACT_CLASS, CMD_START, pick_angle());
          repeat ($urandom_range(1, 6)) push_cmd(ACT_CLASS, pick_steer(), pick_angle());
        end
        5, 6: begin
          push_cmd(ACT_CLASS, CMD_START, pick_angle());
          push_cmd(ACT_CLASS, $urandom_range(1) ? CMD_OBSTACLE : CMD_PARK, pick_angle());
          repeat ($urandom_range(1, 25)) begin
            if ($urandom_range(7) == 0) push_cmd(ACT_CLASS, pick_steer(), pick_angle());
            else push_tick();
          end
          push_cmd(ACT_CLASS, pick_exit(), pick_angle());
        end
        7: begin
          push_cmd(ACT_CLASS, CMD_STOP, pick_angle());
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(1)) push_tick();
            else push_cmd(ACT_CLASS, 4'($urandom_range(2, 15)), pick_angle());
          end
        end
        default: repeat ($urandom_range(1, 4)) push_tick();
      endcase
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_CLASS;
    in_ch.class_code = '0;
    in_ch.angle      = '0;
    out_ch.ready     = 1'b0;
    in_taken         = 1'b0;
    queued           = 0;
    mismatches       = 0;
    drive_cfg.base_speed  = RST_BASE_SPEED;
    drive_cfg.steer_gain  = RST_STEER_GAIN;
    drive_cfg.angle_limit = RST_ANGLE_LIMIT;
    drive_cfg.wheel_min   = RST_WHEEL_MIN;
    drive_cfg.wheel_max   = RST_WHEEL_MAX;
    drive_cfg.side_bias   = RST_SIDE_BIAS;
    drive_en = 1'b0;
    step_now = RT_IDLE;
    step_ms  = '0;
    set_idling(0);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset setting, block disabled at first
    apply_setting(480, 256, 720, -1600, 1600, 80);
    push_cmd(ACT_CLASS, CMD_NORMAL, 100);
    push_tick();
    push_cmd(ACT_CLASS, CMD_HUMAN, 0);
    push_cmd(ACT_CLASS, CMD_START, 0);
    push_cmd(ACT_CLASS, CMD_START, ANGLE_MAX);
    push_cmd(ACT_CLASS, CMD_NORMAL, ANGLE_MIN);
    push_cmd(ACT_CLASS, CMD_NORMAL, 2880);
    push_cmd(ACT_CLASS, CMD_KEEP, 5);
    push_cmd(ACT_CLASS, CMD_NO_LANE, 1234);
    push_cmd(ACT_CLASS, CMD_CROSSWALK, -100);
    push_cmd(ACT_CLASS, CMD_BIAS_LEFT, 50);
    push_cmd(ACT_CLASS, CMD_BIAS_RIGHT, -50);
    push_cmd(ACT_CLASS, CODE_SPARE_LO, 7);
    push_cmd(ACT_CLASS, CODE_SPARE_HI, -7);
    push_cmd(ACT_CLASS, CMD_HUMAN, 0);
    push_cmd(ACT_CLASS, CMD_OBSTACLE, 0);
    push_cmd(ACT_CLASS, CMD_NORMAL, 10);
    push_tick();
    push_tick();
    push_cmd(ACT_CLASS, CMD_PARK, 0);
    push_tick();
    push_cmd(ACT_CLASS, CMD_START, 1);
    push_cmd(ACT_CLASS, CMD_PARK, 0);
    push_cmd(ACT_CLASS, CMD_STOP, 0);
    push_tick();
    settle();

    // complete routines, including a cancel in the second evade step
    push_cmd(ACT_CLASS, CMD_START, 0);
    push_cmd(ACT_CLASS, CMD_OBSTACLE, 0);
    repeat (510) push_tick();
    push_cmd(ACT_CLASS, CMD_HUMAN, 0);
    push_cmd(ACT_CLASS, CMD_OBSTACLE, 0);
    repeat (1001) push_tick();
    push_cmd(ACT_CLASS, CMD_NORMAL, -300);
    push_cmd(ACT_CLASS, CMD_PARK, 0);
    repeat (3501) push_tick();
    push_cmd(ACT_CLASS, CMD_NORMAL, 300);
    settle();

    for (int p = 2; p < 8; p++) begin
      case (p)
        2: apply_setting(4095, 4095, 2880, -4096, 4095, 1023);
        3: apply_setting(0, 0, 0, 0, 0, 0);
        4: apply_setting(4095, 4095, 2880, -200, 300, 1023);
        default: apply_setting($urandom_range(4095), $urandom_range(4095),
                               $urandom_range(2880), -int'($urandom_range(4096)),
                               $urandom_range(4095), $urandom_range(1023));
      endcase
      set_idling(p % 4);
      add_random_burst(220);
      settle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ddcs_pkg.sv
rtl/ddcs_if.sv
rtl/ddcs_cfg.sv
rtl/ddcs_ctrl.sv
rtl/ddcs_steer.sv
rtl/differential_drive_command_sequencer.sv
tb/sv/testbench.sv
